// ===== hw/rtl/randomized_set_swap_remove_defines.svh =====
// Assertion macros shared by the randomized set block.
// Depends on nothing; included by the top level only.
`ifndef RANDOMIZED_SET_SWAP_REMOVE_DEFINES_SVH
`define RANDOMIZED_SET_SWAP_REMOVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSSR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/rssr_pkg.sv =====
// Package for the randomized set block: field widths, operation and status codes.
// Depends on nothing; imported by rssr_mod and the top level.
package rssr_pkg;

    localparam int OP_W        = 2;
    localparam int VALUE_W     = 32;
    localparam int DRAW_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 7;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_INSERT = 2'd0;
    localparam op_t OP_REMOVE = 2'd1;
    localparam op_t OP_RANDOM = 2'd2;

    localparam status_t STAT_OK        = 3'd0;
    localparam status_t STAT_PRESENT   = 3'd1;
    localparam status_t STAT_NOT_FOUND = 3'd2;
    localparam status_t STAT_FULL      = 3'd3;
    localparam status_t STAT_EMPTY     = 3'd4;

    localparam logic [VALUE_W-1:0] EMPTY_MARK = 32'h7fff_ffff;

endpackage

// ===== hw/rtl/rssr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module rssr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/rssr_mod.sv =====
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Depends on rssr_pkg.
module rssr_mod #(
    parameter int DIV_W = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rssr_pkg::DRAW_W-1:0]  dividend,
    input  logic [DIV_W-1:0]             divisor,
    output logic                         done,
    output logic [DIV_W-1:0]             remainder
);
    import rssr_pkg::*;

    localparam int CNT_W = $clog2(DRAW_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DRAW_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DRAW_W-1:0]   dvd_reg, dvd_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W:0]      trial;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    assign trial = {rem_reg, dvd_reg[DRAW_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== hw/rtl/randomized_set_swap_remove.sv =====
// Randomized set: a densely packed store of distinct 32-bit values with a count.
// Depends on rssr_pkg, rssr_ram, rssr_mod and randomized_set_swap_remove_defines.svh.
//
// Usage. A request word (op, item_value, random_draw) is taken on the input
// channel when in_valid and in_ready are both high; exactly one result word
// (success, status, element, element_count) leaves on the output channel for
// every request, in order. The block holds one request at a time: in_ready is
// low from acceptance until the result has been placed in the output register.
// Insert and remove search the occupied slots one per cycle through the
// single read port of the slot RAM; a successful remove then fetches the last
// element and moves it into the freed slot. Get-random runs the bit-serial
// remainder unit, then reads the chosen slot. An unused opcode goes straight
// to the finish state.
// Reset clears the count and all control state; the slot RAM is not cleared,
// as slots at or beyond the count are never read. If the receiver stalls, the
// finished word waits in the output register while the next request is taken
// and worked on; that request then waits for the register to free up.
module randomized_set_swap_remove #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [rssr_pkg::OP_W-1:0]           op,
    input  logic signed [rssr_pkg::VALUE_W-1:0] item_value,
    input  logic [rssr_pkg::DRAW_W-1:0]         random_draw,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                success,
    output logic [rssr_pkg::STATUS_W-1:0]       status,
    output logic signed [rssr_pkg::VALUE_W-1:0] element,
    output logic [rssr_pkg::COUNT_OUT_W-1:0]    element_count
);
    import rssr_pkg::*;

`include "randomized_set_swap_remove_defines.svh"

    // AW indexes a slot; CW also holds the count when the store is full.
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SEARCH   = 8'b0000_0010,
        S_RD_LAST  = 8'b0000_0100,
        S_WR_LAST  = 8'b0000_1000,
        S_MOD      = 8'b0001_0000,
        S_RD_RAND  = 8'b0010_0000,
        S_GET_DATA = 8'b0100_0000,
        S_FINISH   = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic                ok_reg, ok_next;
    status_t             stat_reg, stat_next;
    logic [VALUE_W-1:0]  elem_reg, elem_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;
    status_t             out_stat_reg, out_stat_next;
    logic [VALUE_W-1:0]  out_elem_reg, out_elem_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    logic                ram_wr_en, ram_rd_en;
    logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
    logic [VALUE_W-1:0]  ram_wr_data, ram_rd_data;

    logic                mod_start, mod_done;
    logic [CW-1:0]       mod_rem;

    logic [CW-1:0]       last_slot;
    logic                hit;

    rssr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The divisor is the count, which is never zero when get-random starts.
    rssr_mod #(
        .DIV_W (CW)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (random_draw),
        .divisor   (count_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign last_slot = count_reg - CW'(1);

    // The read issued last cycle has returned; compare it with the key.
    assign hit = cmp_vld_reg && (ram_rd_data == value_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        ok_next        = ok_reg;
        stat_next      = stat_reg;
        elem_next      = elem_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_ok_next    = out_ok_reg;
        out_stat_next  = out_stat_reg;
        out_elem_next  = out_elem_reg;
        out_count_next = out_count_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = count_reg[AW-1:0];
        ram_wr_data    = value_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_reg[AW-1:0];
        mod_start      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op;
                    value_next   = item_value;
                    ok_next      = 1'b0;
                    stat_next    = STAT_OK;
                    elem_next    = '0;
                    scan_next    = '0;
                    cmp_vld_next = 1'b0;
                    priority if (op == OP_INSERT || op == OP_REMOVE)
                    begin
                        state_next = S_SEARCH;
                    end
                    else if (op == OP_RANDOM)
                    begin
                        if (count_reg == '0)
                        begin
                            stat_next  = STAT_EMPTY;
                            elem_next  = EMPTY_MARK;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            mod_start  = 1'b1;
                            state_next = S_MOD;
                        end
                    end
                    else
                    begin
                        // The unused opcode changes nothing and reports zero success, status and element.
                        state_next = S_FINISH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    cmp_vld_next = 1'b0;
                    if (op_reg == OP_INSERT)
                    begin
                        stat_next  = STAT_PRESENT;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        pos_next   = cmp_idx_reg;
                        state_next = S_RD_LAST;
                    end
                end
                else if (scan_reg < count_reg)
                begin
                    ram_rd_en    = 1'b1;
                    ram_rd_addr  = scan_reg[AW-1:0];
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[AW-1:0];
                    scan_next    = scan_reg + CW'(1);
                end
                else if (cmp_vld_reg)
                begin
                    // Last compare missed; conclude next cycle.
                    cmp_vld_next = 1'b0;
                end
                else
                begin
                    state_next = S_FINISH;
                    if (op_reg == OP_INSERT)
                    begin
                        if (count_reg >= CAP_C)
                        begin
                            stat_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = count_reg[AW-1:0];
                            ram_wr_data = value_reg;
                            count_next  = count_reg + CW'(1);
                            ok_next     = 1'b1;
                        end
                    end
                    else
                    begin
                        stat_next = STAT_NOT_FOUND;
                    end
                end
            end

            S_RD_LAST:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = last_slot[AW-1:0];
                state_next  = S_WR_LAST;
            end

            S_WR_LAST:
            begin
                // Move the last element into the freed slot and shrink the set.
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg;
                ram_wr_data = ram_rd_data;
                count_next  = last_slot;
                ok_next     = 1'b1;
                state_next  = S_FINISH;
            end

            S_MOD:
            begin
                if (mod_done)
                begin
                    state_next = S_RD_RAND;
                end
            end

            S_RD_RAND:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = mod_rem[AW-1:0];
                state_next  = S_GET_DATA;
            end

            S_GET_DATA:
            begin
                elem_next  = ram_rd_data;
                ok_next    = 1'b1;
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = ok_reg;
                    out_stat_next  = stat_reg;
                    out_elem_next  = elem_reg;
                    out_count_next = COUNT_OUT_W'(count_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        value_reg     <= value_next;
        scan_reg      <= scan_next;
        cmp_idx_reg   <= cmp_idx_next;
        pos_reg       <= pos_next;
        ok_reg        <= ok_next;
        stat_reg      <= stat_next;
        elem_reg      <= elem_next;
        out_ok_reg    <= out_ok_next;
        out_stat_reg  <= out_stat_next;
        out_elem_reg  <= out_elem_next;
        out_count_reg <= out_count_next;
    end

    assign out_valid     = out_valid_reg;
    assign success       = out_ok_reg;
    assign status        = out_stat_reg;
    assign element       = out_elem_reg;
    assign element_count = out_count_reg;

    // The count never grows past the store size.
    `RSSR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CAP_C, "count above capacity")

    // The count moves by at most one per cycle.
    `RSSR_ASSERT_NEXT(a_count_step, clk, rst_n, 1'b1,
        count_reg == $past(count_reg) || count_reg == $past(count_reg) + CW'(1) ||
        count_reg == $past(count_reg) - CW'(1), "count jumped")

    // The remainder unit finishes only while the sequencer waits for it.
    `RSSR_ASSERT_NOW(a_mod_done_state, clk, rst_n, mod_done, state_reg == S_MOD,
        "remainder finished outside its wait state")

    // A request taken closes the input until its result is produced.
    `RSSR_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready,
        "second request taken while one is in flight")

endmodule
